// ===== rtl/core/lzsd_pkg.sv =====
// Shared types and constants of the LZSS window decompressor.
package lzsd_pkg;

   localparam int WINDOW_SIZE_DEF = 4096;
   localparam int START_POS       = 'hFEE;
   localparam int LEN_W           = 27;
   localparam int FLAG_W          = 9;
   localparam int RUN_W           = 5;

   localparam logic [FLAG_W-1:0] FLAG_MARK = 9'h100;

   localparam logic RESULT_BYTE   = 1'b0;
   localparam logic RESULT_STATUS = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_READ,
      ST_COPY,
      ST_STATUS
   } state_type;

   typedef enum logic [1:0] {
      PH_START = 2'd0,
      PH_MATCH = 2'd1,
      PH_HALT  = 2'd3
   } phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_stream;
   } req_type;

   typedef struct packed {
      logic       result_kind;
      logic [7:0] out_byte;
      logic       run_last;
      logic       length_ok;
   } rsp_type;

   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } win_ctl_type;

endpackage

// ===== rtl/core/lzsd_window.sv =====
// History window RAM with fill-range check so unwritten entries read as zero.
module lzsd_window #(
   parameter int WINDOW_SIZE = lzsd_pkg::WINDOW_SIZE_DEF,
   parameter int AW          = $clog2(WINDOW_SIZE),
   parameter int FW          = $clog2(WINDOW_SIZE + 1)
) (
   input  logic                 clock,
   input  lzsd_pkg::win_ctl_type ctl,
   input  logic [AW-1:0]        wr_addr,
   input  logic [7:0]           wr_data,
   input  logic [AW-1:0]        rd_addr,
   input  logic [FW-1:0]        fill,
   output logic [7:0]           rd_data
);
   import lzsd_pkg::*;

   logic [7:0]    mem [WINDOW_SIZE];
   logic [7:0]    rd_q_ff;
   logic          hit_ff;
   logic [AW-1:0] rel;

   // Distance of the read address from the first written position
   assign rel = rd_addr - AW'(START_POS);

   // Write one word
   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read one word and note whether it lies in the written range
   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_q_ff <= mem[rd_addr];
         hit_ff  <= ({1'b0, rel} < (AW+1)'(fill));
      end
   end

   assign rd_data = hit_ff ? rd_q_ff : 8'h00;

endmodule

// ===== rtl/core/lzss_window_decompressor.sv =====
// Output path: a literal word passes the req register and then the rsp register before it shows.
// Sequence: every input word passes ST_IDLE and ST_DECODE; a match word then copies its L output
// words, each taking one window read (ST_READ) and one write (ST_COPY); ST_STATUS adds the status word.
// New input is taken only in ST_IDLE. rsp stalls hold the sequencer only when the output is full.
// Reset: synchronous, clears control state; window reads as zero through the fill count,
// so neither reset nor end of stream needs a clearing pass.
module lzss_window_decompressor #(
   parameter int WINDOW_SIZE = lzsd_pkg::WINDOW_SIZE_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  lzsd_pkg::req_type            req_payload,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output lzsd_pkg::rsp_type            rsp_payload,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [lzsd_pkg::LEN_W-1:0]   csr_data
);
   import lzsd_pkg::*;

   localparam int AW = $clog2(WINDOW_SIZE);
   localparam int FW = $clog2(WINDOW_SIZE + 1);

   state_type         state_ff, state_in;
   phase_type         phase_ff, phase_in;
   logic [FLAG_W-1:0] flags_ff, flags_in;
   logic [7:0]        offlo_ff, offlo_in;
   logic [AW-1:0]     wpos_ff, wpos_in;
   logic [LEN_W-1:0]  prod_ff, prod_in;
   logic [FW-1:0]     fill_ff, fill_in;
   logic [LEN_W-1:0]  expected_ff;
   req_type           req_ff, req_in;
   logic [AW-1:0]     off_ff, off_in;
   logic [RUN_W-1:0]  lenm1_ff, lenm1_in;
   logic [RUN_W-1:0]  cnt_ff, cnt_in;
   rsp_type           rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;

   win_ctl_type       win_ctl;
   logic [AW-1:0]     rd_addr;
   logic [7:0]        rd_data;
   logic              out_free;
   logic              overrun;
   logic              emit_en;
   logic [7:0]        emit_byte;
   logic              emit_last;
   state_type         after_state;

   // Read address adder: match base plus copy index
   assign rd_addr = off_ff + AW'(cnt_ff);

   lzsd_window #(
      .WINDOW_SIZE(WINDOW_SIZE),
      .AW(AW),
      .FW(FW)
   ) u_window (
      .clock  (clock),
      .ctl    (win_ctl),
      .wr_addr(wpos_ff),
      .wr_data(emit_byte),
      .rd_addr(rd_addr),
      .fill   (fill_ff),
      .rd_data(rd_data)
   );

   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign overrun     = (prod_ff >= expected_ff);
   assign after_state = req_ff.end_of_stream ? ST_STATUS : ST_IDLE;

   assign req_ready   = (state_ff == ST_IDLE);
   assign csr_ready   = 1'b1;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // Sequencer: next state and datapath updates
   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      flags_in     = flags_ff;
      offlo_in     = offlo_ff;
      wpos_in      = wpos_ff;
      prod_in      = prod_ff;
      fill_in      = fill_ff;
      req_in       = req_ff;
      off_in       = off_ff;
      lenm1_in     = lenm1_ff;
      cnt_in       = cnt_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      win_ctl      = '0;
      emit_en      = 1'b0;
      emit_byte    = req_ff.data_byte;
      emit_last    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in   = req_payload;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (phase_ff == PH_MATCH) begin
               off_in   = AW'({req_ff.data_byte[7:4], offlo_ff});
               lenm1_in = {1'b0, req_ff.data_byte[3:0]} + RUN_W'(2);
               cnt_in   = '0;
               phase_in = PH_START;
               state_in = ST_READ;
            end else if (phase_ff == PH_HALT) begin
               state_in = after_state;
            end else if (flags_ff <= FLAG_W'(1)) begin
               // Load a new flag word
               phase_in = PH_START;
               flags_in = FLAG_MARK | {1'b0, req_ff.data_byte};
               state_in = after_state;
            end else if (flags_ff[0]) begin
               // Literal: emit, wait for output space, or halt on overrun
               if (overrun) begin
                  phase_in = PH_HALT;
                  flags_in = flags_ff >> 1;
                  state_in = after_state;
               end else if (out_free) begin
                  phase_in  = PH_START;
                  flags_in  = flags_ff >> 1;
                  emit_en   = 1'b1;
                  emit_last = !req_ff.end_of_stream;
                  state_in  = after_state;
               end
            end else begin
               // Match start: keep the low offset bits
               flags_in = flags_ff >> 1;
               offlo_in = req_ff.data_byte;
               phase_in = PH_MATCH;
               state_in = after_state;
            end
         end
         ST_READ: begin
            if (overrun) begin
               phase_in = PH_HALT;
               state_in = after_state;
            end else begin
               win_ctl.rd_en = 1'b1;
               state_in      = ST_COPY;
            end
         end
         ST_COPY: begin
            if (out_free) begin
               emit_en   = 1'b1;
               emit_byte = rd_data;
               emit_last = !req_ff.end_of_stream &&
                           ((cnt_ff == lenm1_ff) || ((prod_ff + LEN_W'(1)) >= expected_ff));
               if (cnt_ff == lenm1_ff) begin
                  state_in = after_state;
               end else begin
                  cnt_in   = cnt_ff + RUN_W'(1);
                  state_in = ST_READ;
               end
            end
         end
         ST_STATUS: begin
            if (out_free) begin
               rsp_in.result_kind = RESULT_STATUS;
               rsp_in.out_byte    = 8'h00;
               rsp_in.run_last    = 1'b1;
               rsp_in.length_ok   = (phase_ff != PH_HALT) && (prod_ff == expected_ff);
               rsp_valid_in       = 1'b1;
               // Return the stream state to its start values
               phase_in = PH_START;
               flags_in = '0;
               offlo_in = '0;
               wpos_in  = AW'(START_POS);
               prod_in  = '0;
               fill_in  = '0;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Emit one decompressed word and write it into the window
      if (emit_en) begin
         rsp_in.result_kind = RESULT_BYTE;
         rsp_in.out_byte    = emit_byte;
         rsp_in.run_last    = emit_last;
         rsp_in.length_ok   = 1'b0;
         rsp_valid_in       = 1'b1;
         win_ctl.wr_en      = 1'b1;
         wpos_in            = wpos_ff + AW'(1);
         prod_in            = prod_ff + LEN_W'(1);
         fill_in            = (fill_ff == FW'(WINDOW_SIZE)) ? fill_ff : fill_ff + FW'(1);
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_START;
         flags_ff     <= '0;
         offlo_ff     <= '0;
         wpos_ff      <= AW'(START_POS);
         prod_ff      <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         flags_ff     <= flags_in;
         offlo_ff     <= offlo_in;
         wpos_ff      <= wpos_in;
         prod_ff      <= prod_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         expected_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         expected_ff <= csr_data;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      req_ff   <= req_in;
      off_ff   <= off_in;
      lenm1_ff <= lenm1_in;
      cnt_ff   <= cnt_in;
      rsp_ff   <= rsp_in;
   end

   // Fill count never passes the window size
   assert property (@(posedge clock) disable iff (reset) fill_ff <= FW'(WINDOW_SIZE))
      else $error("window fill count beyond window size");

   // A status word always closes its input word's results
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_ff.result_kind == RESULT_STATUS) |-> rsp_ff.run_last)
      else $error("status word without run_last");

   // A decompressed word never reports length_ok
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_ff.result_kind == RESULT_BYTE) |-> !rsp_ff.length_ok)
      else $error("byte word with length_ok set");

   // A copy step always follows a window read or a stalled copy step
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COPY) |-> ($past(state_ff) == ST_READ) || ($past(state_ff) == ST_COPY))
      else $error("copy step without window read");

endmodule
